[rtl/opfcr_pkg.sv]
// ----------------------------------------------------------------------------
// opfcr_pkg
// Shared widths, register indexes, sequencer states and saturation helpers
// for the ramped one-pole filter cascade.
// ----------------------------------------------------------------------------
package opfcr_pkg;

    localparam int CFG_W    = 18;  // widest configuration register
    localparam int IDX_W    = 3;   // configuration register index
    localparam int LEN_W    = 13;  // block length register
    localparam int LEN_MAX  = 8191;
    localparam int SMP_W    = 16;  // input sample
    localparam int OUT_W    = 17;  // saturated stage output
    localparam int MUL_W    = 19;  // signed multiplier operands
    localparam int PROD_W   = 38;  // multiplier product and accumulator
    localparam int SUM_W    = 20;  // pre-saturation sum
    localparam int DIVQ_W   = 36;  // dividend and quotient shift register
    localparam int DIVR_W   = 18;  // divider remainder and divisor
    localparam int RAMPQ_W  = 18;  // ramp quotient, bounded by the coefficients
    localparam int CNT_W    = 6;   // divider step counter

    typedef enum logic [IDX_W-1:0] {
        REG_OUT_RATE      = 3'd0,
        REG_HP_COEF_START = 3'd1,
        REG_HP_COEF_END   = 3'd2,
        REG_LP_COEF_START = 3'd3,
        REG_LP_COEF_END   = 3'd4,
        REG_BLOCK_LEN     = 3'd5
    } cfg_idx_t;

    typedef enum logic [9:0] {
        ST_IDLE     = 10'b00_0000_0001,
        ST_RAMP_A   = 10'b00_0000_0010,
        ST_RAMP_B   = 10'b00_0000_0100,
        ST_RAMP_LD  = 10'b00_0000_1000,
        ST_RAMP_DIV = 10'b00_0001_0000,
        ST_FILT_MUL = 10'b00_0010_0000,
        ST_FILT_LD  = 10'b00_0100_0000,
        ST_FILT_DIV = 10'b00_1000_0000,
        ST_FILT_END = 10'b01_0000_0000,
        ST_DONE     = 10'b10_0000_0000
    } state_t;

    typedef enum logic {
        STAGE_HP = 1'b0,
        STAGE_LP = 1'b1
    } stage_t;

    localparam logic signed [SUM_W-1:0] SAT_HI = 20'sd65535;
    localparam logic signed [SUM_W-1:0] SAT_LO = -20'sd65536;

    function automatic logic signed [OUT_W-1:0] sat17(input logic signed [SUM_W-1:0] v);
        logic signed [OUT_W-1:0] r;
        if (v > SAT_HI)
        begin
            r = SAT_HI[OUT_W-1:0];
        end
        else if (v < SAT_LO)
        begin
            r = SAT_LO[OUT_W-1:0];
        end
        else
        begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

    // Keep the low 16 bits and sign-extend them.
    function automatic logic signed [OUT_W-1:0] wrap16(input logic signed [OUT_W-1:0] v);
        return {v[SMP_W-1], v[SMP_W-1:0]};
    endfunction

endpackage

[rtl/one_pole_filter_cascade_ramped.sv]
// ----------------------------------------------------------------------------
// one_pole_filter_cascade_ramped
// Each sample of a channel passes a one-pole high-pass and then a one-pole
// low-pass filter, with both coefficients ramped linearly across a block of
// block_len samples. One signed 19x19 multiplier and one restoring divider
// that retires one quotient bit per cycle do all the arithmetic under a small
// sequencer, so the block takes one sample at a time. An active stage runs
// ST_RAMP_A, ST_RAMP_B and ST_RAMP_LD for the ramp numerator, 18 divider steps
// for the ramped coefficient, ST_FILT_MUL and ST_FILT_LD for the product, 36
// divider steps for the division by out_rate, then ST_FILT_END. A sample with
// both stages bypassed goes from ST_IDLE to ST_DONE; in_stall stays high while
// a sample is in flight. The result sits in an output register, so a stalled
// output holds back the next sample only when that sample is finished too.
// The user must write configuration through cfg_valid/cfg_index/cfg_data only
// while no sample is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module one_pole_filter_cascade_ramped
    import opfcr_pkg::*;
#(
    parameter int CHANNELS  = 2,
    parameter int MAX_BLOCK = 4096
)
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     channel,
    input  logic signed [SMP_W-1:0]  sample,

    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [OUT_W-1:0]  filtered,
    output logic                     block_end,

    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [IDX_W-1:0]         cfg_index,
    input  logic [CFG_W-1:0]         cfg_data
);

    localparam int LEN_CAP = (MAX_BLOCK < LEN_MAX) ? MAX_BLOCK : LEN_MAX;
    localparam int POS_W   = $clog2(LEN_CAP);

    // Configuration registers.
    logic [CFG_W-1:0] rate_reg,     rate_next;
    logic [CFG_W-1:0] hp_start_reg, hp_start_next;
    logic [CFG_W-1:0] hp_end_reg,   hp_end_next;
    logic [CFG_W-1:0] lp_start_reg, lp_start_next;
    logic [CFG_W-1:0] lp_end_reg,   lp_end_next;
    logic [LEN_W-1:0] blen_reg,     blen_next;

    // Per-channel filter state.
    logic signed [SMP_W-1:0] hp_in_reg  [CHANNELS];
    logic signed [SMP_W-1:0] hp_in_next [CHANNELS];
    logic signed [OUT_W-1:0] hp_out_reg  [CHANNELS];
    logic signed [OUT_W-1:0] hp_out_next [CHANNELS];
    logic signed [OUT_W-1:0] lp_out_reg  [CHANNELS];
    logic signed [OUT_W-1:0] lp_out_next [CHANNELS];
    logic [POS_W-1:0]        pos_reg  [CHANNELS];
    logic [POS_W-1:0]        pos_next [CHANNELS];

    // Sequencer and working registers.
    state_t                   state_reg, state_next;
    stage_t                   stage_reg, stage_next;
    logic                     ch_reg, ch_next;
    logic signed [SMP_W-1:0]  x_reg, x_next;
    logic signed [OUT_W-1:0]  y_reg, y_next;
    logic [LEN_W-1:0]         len_reg, len_next;
    logic [LEN_W-1:0]         pcur_reg, pcur_next;
    logic                     last_reg, last_next;
    logic signed [PROD_W-1:0] acc_reg, acc_next;
    logic [DIVR_W-1:0]        rem_reg, rem_next;
    logic [DIVQ_W-1:0]        q_reg, q_next;
    logic [DIVR_W-1:0]        div_reg, div_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     neg_reg, neg_next;

    // Output register.
    logic                     out_valid_reg, out_valid_next;
    logic signed [OUT_W-1:0]  filtered_reg, filtered_next;
    logic                     block_end_reg, block_end_next;

    // Combinational helpers.
    logic                     hp_en, lp_en;
    logic                     ch_in;
    logic [LEN_W-1:0]         len_in, pos_raw, pos_in;
    logic [CFG_W-1:0]         rate_eff;
    logic [CFG_W-1:0]         coef_start, coef_end;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [MUL_W-1:0]  filt_diff;
    logic [DIVR_W:0]          r_sh, r_sub;
    logic                     r_ge;
    logic [DIVR_W-1:0]        rem_step;
    logic [DIVQ_W-1:0]        q_step;
    logic [PROD_W-1:0]        acc_mag;
    logic [RAMPQ_W-1:0]       q_clamp;
    logic signed [MUL_W-1:0]  q_signed;
    logic signed [OUT_W-1:0]  stage_y;
    logic                     in_xfer, out_xfer, out_load;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_xfer  = out_valid_reg && !out_stall;
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    assign out_valid = out_valid_reg;
    assign filtered  = filtered_reg;
    assign block_end = block_end_reg;

    assign hp_en    = (hp_start_reg != '0) || (hp_end_reg != '0);
    assign lp_en    = (lp_start_reg != '0) || (lp_end_reg != '0);
    assign rate_eff = (rate_reg == '0) ? CFG_W'(1) : rate_reg;

    // Block length and position of the arriving sample.
    always_comb
    begin
        ch_in = (int'(channel) < CHANNELS) ? channel : 1'b0;
        if (blen_reg == '0)
        begin
            len_in = LEN_W'(1);
        end
        else if (int'(blen_reg) > LEN_CAP)
        begin
            len_in = LEN_W'(LEN_CAP);
        end
        else
        begin
            len_in = blen_reg;
        end
        pos_raw = LEN_W'(pos_reg[ch_in]);
        pos_in  = (pos_raw >= len_in) ? (len_in - LEN_W'(1)) : pos_raw;
    end

    assign coef_start = (stage_reg == STAGE_HP) ? hp_start_reg : lp_start_reg;
    assign coef_end   = (stage_reg == STAGE_HP) ? hp_end_reg   : lp_end_reg;

    // The filter difference fits 19 bits: both stages work on 17-bit values.
    always_comb
    begin
        if (stage_reg == STAGE_HP)
        begin
            filt_diff = MUL_W'(hp_out_reg[ch_reg]) + MUL_W'(x_reg)
                      - MUL_W'(hp_in_reg[ch_reg]);
        end
        else
        begin
            filt_diff = MUL_W'(y_reg) - MUL_W'(lp_out_reg[ch_reg]);
        end
    end

    // Shared multiplier.
    always_comb
    begin
        priority case (1'b1)
            state_reg == ST_RAMP_A:
            begin
                mul_a = MUL_W'(coef_start);
                mul_b = MUL_W'(len_reg - pcur_reg);
            end
            state_reg == ST_RAMP_B:
            begin
                mul_a = MUL_W'(coef_end);
                mul_b = MUL_W'(pcur_reg);
            end
            default:
            begin
                mul_a = MUL_W'(q_reg[RAMPQ_W-1:0]);
                mul_b = filt_diff;
            end
        endcase
    end

    assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

    // One restoring division step.
    assign r_sh     = {rem_reg, q_reg[DIVQ_W-1]};
    assign r_ge     = (r_sh >= {1'b0, div_reg});
    assign r_sub    = r_sh - {1'b0, div_reg};
    assign rem_step = r_ge ? r_sub[DIVR_W-1:0] : r_sh[DIVR_W-1:0];
    assign q_step   = {q_reg[DIVQ_W-2:0], r_ge};

    assign acc_mag = acc_reg[PROD_W-1] ? PROD_W'(-acc_reg) : PROD_W'(acc_reg);

    // A quotient magnitude of 2^18 or more saturates either stage anyway, so it
    // is clamped before the sign is applied.
    always_comb
    begin
        q_clamp  = (|q_reg[DIVQ_W-1:RAMPQ_W]) ? '1 : q_reg[RAMPQ_W-1:0];
        q_signed = neg_reg ? -MUL_W'(q_clamp) : MUL_W'(q_clamp);
        if (stage_reg == STAGE_HP)
        begin
            stage_y = sat17(SUM_W'(q_signed));
        end
        else
        begin
            stage_y = sat17(SUM_W'(lp_out_reg[ch_reg]) + SUM_W'(q_signed));
        end
    end

    always_comb
    begin
        rate_next     = rate_reg;
        hp_start_next = hp_start_reg;
        hp_end_next   = hp_end_reg;
        lp_start_next = lp_start_reg;
        lp_end_next   = lp_end_reg;
        blen_next     = blen_reg;
        hp_in_next    = hp_in_reg;
        hp_out_next   = hp_out_reg;
        lp_out_next   = lp_out_reg;
        pos_next      = pos_reg;
        state_next    = state_reg;
        stage_next    = stage_reg;
        ch_next       = ch_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        len_next      = len_reg;
        pcur_next     = pcur_reg;
        last_next     = last_reg;
        acc_next      = acc_reg;
        rem_next      = rem_reg;
        q_next        = q_reg;
        div_next      = div_reg;
        cnt_next      = cnt_reg;
        neg_next      = neg_reg;
        filtered_next  = filtered_reg;
        block_end_next = block_end_reg;
        out_valid_next = out_valid_reg;

        if (out_xfer)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_OUT_RATE:      rate_next     = cfg_data;
                REG_HP_COEF_START: hp_start_next = cfg_data;
                REG_HP_COEF_END:   hp_end_next   = cfg_data;
                REG_LP_COEF_START: lp_start_next = cfg_data;
                REG_LP_COEF_END:   lp_end_next   = cfg_data;
                REG_BLOCK_LEN:     blen_next     = cfg_data[LEN_W-1:0];
                default:           ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    ch_next   = ch_in;
                    x_next    = sample;
                    y_next    = OUT_W'(sample);
                    len_next  = len_in;
                    pcur_next = pos_in;
                    last_next = ((pos_in + LEN_W'(1)) == len_in);
                    if (hp_en)
                    begin
                        stage_next = STAGE_HP;
                        state_next = ST_RAMP_A;
                    end
                    else if (lp_en)
                    begin
                        stage_next = STAGE_LP;
                        state_next = ST_RAMP_A;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_RAMP_A:
            begin
                acc_next   = prod;
                state_next = ST_RAMP_B;
            end
            ST_RAMP_B:
            begin
                acc_next   = acc_reg + prod;
                state_next = ST_RAMP_LD;
            end
            ST_RAMP_LD:
            begin
                // The quotient is below 2^18, so the high numerator bits
                // already form a remainder smaller than the block length.
                rem_next   = DIVR_W'(acc_reg[RAMPQ_W+LEN_W-1:RAMPQ_W]);
                q_next     = {acc_reg[RAMPQ_W-1:0], (DIVQ_W-RAMPQ_W)'(0)};
                div_next   = DIVR_W'(len_reg);
                cnt_next   = CNT_W'(RAMPQ_W);
                state_next = ST_RAMP_DIV;
            end
            ST_RAMP_DIV, ST_FILT_DIV:
            begin
                rem_next = rem_step;
                q_next   = q_step;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = (state_reg == ST_RAMP_DIV) ? ST_FILT_MUL : ST_FILT_END;
                end
            end
            ST_FILT_MUL:
            begin
                acc_next   = prod;
                state_next = ST_FILT_LD;
            end
            ST_FILT_LD:
            begin
                neg_next   = acc_reg[PROD_W-1];
                q_next     = acc_mag[DIVQ_W-1:0];
                rem_next   = '0;
                div_next   = rate_eff;
                cnt_next   = CNT_W'(DIVQ_W);
                state_next = ST_FILT_DIV;
            end
            ST_FILT_END:
            begin
                y_next = stage_y;
                if (stage_reg == STAGE_HP)
                begin
                    hp_in_next[ch_reg]  = x_reg;
                    hp_out_next[ch_reg] = stage_y;
                end
                else
                begin
                    lp_out_next[ch_reg] = stage_y;
                end
                if (stage_reg == STAGE_HP && lp_en)
                begin
                    stage_next = STAGE_LP;
                    state_next = ST_RAMP_A;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    filtered_next  = y_reg;
                    block_end_next = last_reg;
                    if (last_reg)
                    begin
                        hp_out_next[ch_reg] = wrap16(hp_out_reg[ch_reg]);
                        lp_out_next[ch_reg] = wrap16(lp_out_reg[ch_reg]);
                        pos_next[ch_reg]    = '0;
                    end
                    else
                    begin
                        pos_next[ch_reg] = POS_W'(pcur_reg + LEN_W'(1));
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg      <= CFG_W'(44100);
            hp_start_reg  <= '0;
            hp_end_reg    <= '0;
            lp_start_reg  <= '0;
            lp_end_reg    <= '0;
            blen_reg      <= LEN_W'(256);
            state_reg     <= ST_IDLE;
            stage_reg     <= STAGE_HP;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                hp_in_reg[c]  <= '0;
                hp_out_reg[c] <= '0;
                lp_out_reg[c] <= '0;
                pos_reg[c]    <= '0;
            end
        end
        else
        begin
            rate_reg      <= rate_next;
            hp_start_reg  <= hp_start_next;
            hp_end_reg    <= hp_end_next;
            lp_start_reg  <= lp_start_next;
            lp_end_reg    <= lp_end_next;
            blen_reg      <= blen_next;
            state_reg     <= state_next;
            stage_reg     <= stage_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            hp_in_reg     <= hp_in_next;
            hp_out_reg    <= hp_out_next;
            lp_out_reg    <= lp_out_next;
            pos_reg       <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg        <= ch_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        len_reg       <= len_next;
        pcur_reg      <= pcur_next;
        last_reg      <= last_next;
        acc_reg       <= acc_next;
        rem_reg       <= rem_next;
        q_reg         <= q_next;
        div_reg       <= div_next;
        neg_reg       <= neg_next;
        filtered_reg  <= filtered_next;
        block_end_reg <= block_end_next;
    end

    // A transferred sample keeps the block busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> in_stall)
        else $error("block not busy after an input transfer");

    // A new result appears only out of the final sequencer state.
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("output loaded outside the final state");

    // While dividing, the remainder stays below the divisor and the step count is nonzero.
    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RAMP_DIV || state_reg == ST_FILT_DIV)
            |-> (rem_reg < div_reg) && (cnt_reg != '0))
        else $error("divider remainder or step count out of range");

    // A ramped coefficient never exceeds the larger end coefficient's width.
    a_ramp_quotient: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILT_MUL) |-> (q_reg[DIVQ_W-1:RAMPQ_W] == '0))
        else $error("ramped coefficient overflowed");

endmodule
